>>> rtl/bounded_greedy_graph_coloring_macros.svh
`ifndef BOUNDED_GREEDY_GRAPH_COLORING_MACROS_SVH
`define BOUNDED_GREEDY_GRAPH_COLORING_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BGC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bgc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BGC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bgc assertion failed");

`endif

>>> rtl/bgc_pkg.sv
package bgc_pkg;

	localparam int NB_W     = 10;
	localparam int COLOR_W  = 6;
	localparam int USED_W   = 7;
	localparam int CAP_W    = 11;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd8;

	localparam int DEF_MAX_ELEMS  = 1024;
	localparam int DEF_MAX_COLORS = 64;

	typedef struct packed {
		logic               found;
		logic [COLOR_W-1:0] color;
	} pick_t;

endpackage

>>> rtl/bgc_ifs.sv
interface bgc_nbr_if;
	import bgc_pkg::*;
	logic            valid;
	logic            ready;
	logic [NB_W-1:0] neighbor_index;
	logic            has_neighbor;
	logic            last_neighbor;
	logic            first_of_leaf;

	modport source (output valid, neighbor_index, has_neighbor, last_neighbor,
		first_of_leaf, input ready);
	modport sink (input valid, neighbor_index, has_neighbor, last_neighbor,
		first_of_leaf, output ready);
endinterface

interface bgc_res_if;
	import bgc_pkg::*;
	logic               valid;
	logic               ready;
	logic [NB_W-1:0]    element_index;
	logic [COLOR_W-1:0] assigned_color;
	logic [USED_W-1:0]  colors_used;
	logic               out_of_colors;

	modport source (output valid, element_index, assigned_color, colors_used,
		out_of_colors, input ready);
	modport sink (input valid, element_index, assigned_color, colors_used,
		out_of_colors, output ready);
endinterface

interface bgc_cfg_if;
	import bgc_pkg::*;
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> rtl/bounded_greedy_graph_coloring.sv
// Greedy first-fit graph coloring, one neighbor entry per item.
// Throughput: one item per cycle unless a last_neighbor item waits on a full result;
// the pick is combinational; a result passes the s1 and result registers in turn.
// Reset (arst_n low, async): use counts, mask, counter, highest color cleared,
// capacity back to 8, pipeline empty; the color store keeps no reset.
`include "bounded_greedy_graph_coloring_macros.svh"

module bounded_greedy_graph_coloring
	import bgc_pkg::*;
#(
	parameter int MAX_ELEMS  = DEF_MAX_ELEMS,
	parameter int MAX_COLORS = DEF_MAX_COLORS
) (
	input logic      clk,
	input logic      arst_n,
	bgc_cfg_if.sink  cfg,
	bgc_nbr_if.sink  nbr,
	bgc_res_if.source res
);

	localparam int AW = $clog2(MAX_ELEMS);
	localparam int CW = $clog2(MAX_ELEMS + 1);

	logic [CAP_W-1:0] cap_q;

	logic            s1_valid_q;
	logic [NB_W-1:0] nb_s1;
	logic            has_s1;
	logic            last_s1;
	logic            first_s1;

	logic [CW-1:0]         cnt_q;
	logic [MAX_COLORS-1:0] mask_q;
	logic [USED_W-1:0]     high_q;
	logic [CAP_W-1:0]      color_cnt_q [MAX_COLORS];

	logic               res_valid_q;
	logic [NB_W-1:0]    res_index_q;
	logic [COLOR_W-1:0] res_color_q;
	logic [USED_W-1:0]  res_used_q;
	logic               res_ooc_q;

	logic                  accept;
	logic                  s1_go;
	logic [CW-1:0]         cnt_eff;
	logic [MAX_COLORS-1:0] mask_eff;
	logic [USED_W-1:0]     high_eff;
	logic [CAP_W-1:0]      color_cnt_eff [MAX_COLORS];
	logic [COLOR_W-1:0]    rd_color;
	logic                  hit;
	logic                  room;
	pick_t                 pk;
	logic                  found;
	logic [USED_W-1:0]     color_p1;
	logic [USED_W-1:0]     high_new;
	logic [AW+NB_W-1:0]    nb_ext;
	logic [CW+NB_W-1:0]    cnt_ext;
	logic [CW+NB_W-1:0]    nb_cmp;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.data;
		end
	end

	// handshake: non-last items never need the output register
	assign s1_go     = s1_valid_q && (!last_s1 || !res_valid_q || res.ready);
	assign nbr.ready = !s1_valid_q || s1_go;
	assign accept    = nbr.valid && nbr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (nbr.ready) begin
			s1_valid_q <= nbr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nb_s1    <= nbr.neighbor_index;
			has_s1   <= nbr.has_neighbor;
			last_s1  <= nbr.last_neighbor;
			first_s1 <= nbr.first_of_leaf;
		end
	end

	assign nb_ext = {{AW{1'b0}}, nbr.neighbor_index};

	bgc_color_mem #(
		.DEPTH (MAX_ELEMS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (nb_ext[AW-1:0]),
		.rd_data (rd_color),
		.wr_en   (s1_go && found),
		.wr_addr (cnt_eff[AW-1:0]),
		.wr_data (pk.color)
	);

	// leaf state as seen by the item in s1, with a new leaf cleared first
	always_comb begin
		cnt_eff  = first_s1 ? '0 : cnt_q;
		high_eff = first_s1 ? '0 : high_q;
		for (int c = 0; c < MAX_COLORS; c++) begin
			color_cnt_eff[c] = first_s1 ? '0 : color_cnt_q[c];
		end
	end

	assign cnt_ext = {{NB_W{1'b0}}, cnt_eff};
	assign nb_cmp  = {{CW{1'b0}}, nb_s1};
	assign hit     = has_s1 && (nb_cmp < cnt_ext) &&
		({1'b0, rd_color} < USED_W'(MAX_COLORS));

	always_comb begin
		mask_eff = first_s1 ? '0 : mask_q;
		for (int c = 0; c < MAX_COLORS; c++) begin
			if (hit && (rd_color == COLOR_W'(c))) begin
				mask_eff[c] = 1'b1;
			end
		end
	end

	assign room = cnt_eff < CW'(MAX_ELEMS);

	bgc_pick #(
		.MAX_COLORS (MAX_COLORS)
	) u_pick (
		.en       (last_s1 && room),
		.mask     (mask_eff),
		.cnt      (color_cnt_eff),
		.capacity (cap_q),
		.pick     (pk)
	);

	assign found    = pk.found;
	assign color_p1 = {1'b0, pk.color} + 1'b1;
	assign high_new = (found && (color_p1 > high_eff)) ? color_p1 : high_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			mask_q <= '0;
			high_q <= '0;
			for (int c = 0; c < MAX_COLORS; c++) begin
				color_cnt_q[c] <= '0;
			end
		end else if (s1_go) begin
			cnt_q  <= (last_s1 && room) ? CW'(cnt_eff + 1'b1) : cnt_eff;
			mask_q <= last_s1 ? '0 : mask_eff;
			high_q <= high_new;
			for (int c = 0; c < MAX_COLORS; c++) begin
				color_cnt_q[c] <= (found && (pk.color == COLOR_W'(c))) ?
					CAP_W'(color_cnt_eff[c] + 1'b1) : color_cnt_eff[c];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			res_index_q <= cnt_ext[NB_W-1:0];
			res_color_q <= found ? pk.color : '0;
			res_used_q  <= high_new;
			res_ooc_q   <= !found;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.element_index  = res_index_q;
	assign res.assigned_color = res_color_q;
	assign res.colors_used    = res_used_q;
	assign res.out_of_colors  = res_ooc_q;

	`BGC_ASSERT_IMPL(a_color_in_range, res.valid && !res.out_of_colors,
		({1'b0, res.assigned_color} < USED_W'(MAX_COLORS)) &&
		(res.colors_used > {1'b0, res.assigned_color}))
	`BGC_ASSERT_NEXT(a_result_follows, s1_go && last_s1, res.valid)
	`BGC_ASSERT_NEXT(a_counter_step, s1_go && last_s1 && room,
		cnt_q == CW'($past(cnt_eff) + 1'b1))
	`BGC_ASSERT_IMPL(a_counter_bound, s1_valid_q, cnt_q <= CW'(MAX_ELEMS))

endmodule

>>> rtl/bgc_color_mem.sv
module bgc_color_mem
	import bgc_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_ELEMS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [COLOR_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [COLOR_W-1:0] wr_data
);

	logic [COLOR_W-1:0] mem [DEPTH];
	logic [COLOR_W-1:0] mem_rd_q;
	logic [COLOR_W-1:0] fwd_data_q;
	logic               fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read sees old data on a same-cycle write; the bypass covers that case
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			fwd_q      <= wr_en && (wr_addr == rd_addr);
			fwd_data_q <= wr_data;
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : mem_rd_q;

endmodule

>>> rtl/bgc_pick.sv
module bgc_pick
	import bgc_pkg::*;
#(
	parameter int MAX_COLORS = DEF_MAX_COLORS
) (
	input  logic                  en,
	input  logic [MAX_COLORS-1:0] mask,
	input  logic [CAP_W-1:0]      cnt [MAX_COLORS],
	input  logic [CAP_W-1:0]      capacity,
	output pick_t                 pick
);

	// first fit: lowest color not in the mask with room left
	always_comb begin
		pick = '0;
		for (int c = MAX_COLORS - 1; c >= 0; c--) begin
			if (en && !mask[c] && (cnt[c] < capacity)) begin
				pick.found = 1'b1;
				pick.color = COLOR_W'(c);
			end
		end
	end

endmodule

>>> tb/bounded_greedy_graph_coloring_test.sv
`timescale 1ns / 1ps

module bounded_greedy_graph_coloring_test;
	import bgc_pkg::*;

	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		logic [NB_W-1:0] idx;
		logic            has_nb;
		logic            last;
		logic            first;
	} nbr_entry_t;

	typedef struct packed {
		logic [NB_W-1:0]    element_index;
		logic [COLOR_W-1:0] assigned_color;
		logic [USED_W-1:0]  colors_used;
		logic               out_of_colors;
	} coloring_t;

	logic clk = 1'b0;
	logic arst_n;

	bgc_cfg_if cfg_ch();
	bgc_nbr_if nbr_ch();
	bgc_res_if res_ch();

	bounded_greedy_graph_coloring u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.nbr    (nbr_ch),
		.res    (res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow of the coloring state
	logic [COLOR_W-1:0] color_mem [DEF_MAX_ELEMS];
	bit                 color_written [DEF_MAX_ELEMS];
	logic [CAP_W-1:0]   use_count [DEF_MAX_COLORS];
	logic [63:0]        nbr_mask = '0;
	int unsigned        elem_count = 0;
	logic [USED_W-1:0]  top_color = '0;
	logic [CAP_W-1:0]   capacity = CAP_RESET;

	coloring_t pending_colorings [$];

	int fail_count = 0;
	int entries_sent = 0;
	int results_checked = 0;
	int uncolored_seen = 0;
	int cap_writes = 0;
	bit no_idle = 1'b0;
	int hold_cycles = 0;

	task automatic predict_coloring(input nbr_entry_t e);
		coloring_t r;
		pick_t p;
		if (e.first) begin
			foreach (use_count[c]) use_count[c] = '0;
			nbr_mask = '0;
			elem_count = 0;
			top_color = '0;
		end
		if (e.has_nb && e.idx < elem_count)
			nbr_mask[color_mem[e.idx]] = 1'b1;
		if (e.last) begin
			p = '0;
			// scan downward so the lowest free color wins
			if (elem_count < DEF_MAX_ELEMS)
				for (int c = DEF_MAX_COLORS - 1; c >= 0; c--)
					if (!nbr_mask[c] && use_count[c] < capacity) begin
						p.found = 1'b1;
						p.color = COLOR_W'(c);
					end
			r.element_index = elem_count[NB_W-1:0];
			r.out_of_colors = !p.found;
			r.assigned_color = p.found ? p.color : '0;
			if (p.found) begin
				color_mem[elem_count] = p.color;
				color_written[elem_count] = 1'b1;
				use_count[p.color] = use_count[p.color] + 1'b1;
				if (USED_W'(p.color) + 1'b1 > top_color)
					top_color = USED_W'(p.color) + 1'b1;
			end
			r.colors_used = top_color;
			if (elem_count < DEF_MAX_ELEMS)
				elem_count++;
			nbr_mask = '0;
			pending_colorings.push_back(r);
		end
	endtask

	function automatic nbr_entry_t entry(input logic [NB_W-1:0] idx, input logic has_nb,
			input logic last, input logic first);
		nbr_entry_t e;
		e.idx = idx;
		e.has_nb = has_nb;
		e.last = last;
		e.first = first;
		return e;
	endfunction

	task automatic send_entry(input nbr_entry_t e);
		int unsigned live;
		live = e.first ? 0 : elem_count;
		// never look up a store slot that was never written
		if (e.has_nb && e.idx < live && !color_written[e.idx])
			e.has_nb = 1'b0;
		while (!no_idle && $urandom_range(99) < 13) begin
			nbr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		nbr_ch.valid <= 1'b1;
		nbr_ch.neighbor_index <= e.idx;
		nbr_ch.has_neighbor <= e.has_nb;
		nbr_ch.last_neighbor <= e.last;
		nbr_ch.first_of_leaf <= e.first;
		predict_coloring(e);
		entries_sent++;
		do @(posedge clk); while (!nbr_ch.ready);
	endtask

	task automatic settle(input int extra);
		nbr_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_colorings.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		capacity = v;
		cap_writes++;
	endtask

	task automatic send_element(input bit first, input int refs);
		nbr_entry_t e;
		int roll;
		for (int k = 0; k < refs; k++) begin
			roll = $urandom_range(99);
			e.first = (first && k == 0) || ($urandom_range(99) < 2);
			e.last = (k == refs - 1);
			e.has_nb = (roll >= 8);
			if (roll < 80 && elem_count > 0 && !e.first)
				e.idx = NB_W'($urandom_range(elem_count - 1));
			else
				e.idx = NB_W'($urandom());
			send_entry(e);
		end
	endtask

	task automatic send_leaf(input bit fresh, input int n_elems, input int max_refs);
		for (int i = 0; i < n_elems; i++)
			send_element(fresh && i == 0,
				($urandom_range(99) < 60) ? $urandom_range(1, 2) : $urandom_range(1, max_refs));
	endtask

	task automatic test_directed();
		send_entry(entry(10'h3FF, 1'b0, 1'b1, 1'b1)); // lone element
		send_entry(entry(10'd0, 1'b1, 1'b1, 1'b0));
		send_entry(entry(10'd2, 1'b1, 1'b0, 1'b0));   // itself, ignored
		send_entry(entry(10'h3FF, 1'b1, 1'b0, 1'b0)); // not colored yet
		send_entry(entry(10'd1, 1'b0, 1'b0, 1'b0));   // index without neighbor
		send_entry(entry(10'd0, 1'b1, 1'b0, 1'b0));
		send_entry(entry(10'd1, 1'b1, 1'b1, 1'b0));
		send_entry(entry(10'h155, 1'b1, 1'b1, 1'b0));
		send_entry(entry(10'h2AA, 1'b0, 1'b1, 1'b0));
		send_entry(entry(10'd2, 1'b1, 1'b1, 1'b0));
		send_entry(entry(10'd1, 1'b1, 1'b0, 1'b0));
		send_entry(entry(10'd0, 1'b0, 1'b1, 1'b1));   // new leaf mid element drops mask
		send_entry(entry(10'd0, 1'b1, 1'b1, 1'b1));
		// fill color 0 up to the reset capacity
		repeat (9) send_entry(entry(10'd0, 1'b0, 1'b1, 1'b0));
		send_entry(entry(10'd8, 1'b1, 1'b1, 1'b0));
	endtask

	task automatic test_color_exhaustion();
		settle(DRAIN_CYCLES);
		write_capacity(11'd1);
		for (int i = 0; i < DEF_MAX_COLORS; i++)
			send_entry(entry(NB_W'($urandom()), 1'b0, 1'b1, i == 0));
		settle(DRAIN_CYCLES);
		write_capacity(11'd2);
		// every color is a neighbor: no free color although counts allow
		for (int j = 0; j < DEF_MAX_COLORS; j++)
			send_entry(entry(NB_W'(j), 1'b1, j == DEF_MAX_COLORS - 1, 1'b0));
		// second use of every color, then counts run out
		for (int i = 0; i <= DEF_MAX_COLORS; i++)
			send_entry(entry(NB_W'($urandom()), 1'b0, 1'b1, 1'b0));
	endtask

	task automatic test_long_leaf();
		nbr_entry_t e;
		settle(DRAIN_CYCLES);
		write_capacity(11'd2047);
		for (int i = 0; i < DEF_MAX_ELEMS + 6; i++) begin
			e.first = (i == 0);
			e.last = 1'b1;
			e.has_nb = ($urandom_range(99) < 70);
			e.idx = (elem_count > 0 && i != 0) ? NB_W'($urandom_range(elem_count - 1))
				: NB_W'($urandom());
			send_entry(e);
		end
	endtask

	task automatic test_random_leaves();
		logic [CAP_W-1:0] caps [8];
		int start;
		caps = '{11'd1, 11'd2, 11'd3, 11'd0, 11'd2047, 11'd1024, 11'd5,
			CAP_W'($urandom_range(1, 16))};
		for (int ph = 0; ph < 8; ph++) begin
			settle(DRAIN_CYCLES);
			write_capacity(caps[ph]);
			no_idle = (ph == 2);
			if (ph == 4)
				hold_cycles = 150;
			start = entries_sent;
			while (entries_sent - start < 30) begin
				send_leaf($urandom_range(99) < 90, $urandom_range(1, 12), 6);
				if (ph == 5 && entries_sent - start < 15)
					settle(0);
			end
		end
		no_idle = 1'b0;
	endtask

	task automatic report(input string field, input logic [15:0] want, input logic [15:0] got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		fail_count++;
	endtask

	initial begin : result_sink
		coloring_t want;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				if (pending_colorings.size() == 0) begin
					$display("%0t: result with none expected, actual element %0h color %0h",
						$time, res_ch.element_index, res_ch.assigned_color);
					fail_count++;
				end else begin
					want = pending_colorings.pop_front();
					results_checked++;
					if (want.out_of_colors)
						uncolored_seen++;
					if (res_ch.element_index !== want.element_index)
						report("element_index", 16'(want.element_index),
							16'(res_ch.element_index));
					if (res_ch.assigned_color !== want.assigned_color)
						report("assigned_color", 16'(want.assigned_color),
							16'(res_ch.assigned_color));
					if (res_ch.colors_used !== want.colors_used)
						report("colors_used", 16'(want.colors_used),
							16'(res_ch.colors_used));
					if (res_ch.out_of_colors !== want.out_of_colors)
						report("out_of_colors", 16'(want.out_of_colors),
							16'(res_ch.out_of_colors));
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= no_idle || $urandom_range(99) >= 13;
			end
		end
	end

	initial begin
		#2000000;
		$display("%0t: timeout, %0d results outstanding", $time, pending_colorings.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin
		foreach (use_count[c]) use_count[c] = '0;
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		nbr_ch.valid <= 1'b0;
		nbr_ch.neighbor_index <= '0;
		nbr_ch.has_neighbor <= 1'b0;
		nbr_ch.last_neighbor <= 1'b0;
		nbr_ch.first_of_leaf <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_color_exhaustion();
		test_long_leaf();
		test_random_leaves();
		settle(2 * DRAIN_CYCLES);
		$display("Run covered %0d entries, %0d colorings checked, %0d left uncolored",
			entries_sent, results_checked, uncolored_seen);
		$display("Capacity written %0d times (0 through 2047), one leaf past %0d elements",
			cap_writes, DEF_MAX_ELEMS);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> bounded_greedy_graph_coloring.f
+incdir+rtl
rtl/bgc_pkg.sv
rtl/bgc_ifs.sv
rtl/bgc_color_mem.sv
rtl/bgc_pick.sv
rtl/bounded_greedy_graph_coloring.sv
tb/bounded_greedy_graph_coloring_test.sv
